[sv/jfsp_pkg.sv]
`default_nettype none
package jfsp_pkg;

  // One byte of the file buffer with its framing marks.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_t;

  // One probe result.
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
  } out_t;

  // Result handed from the parser to the output stage.
  typedef struct packed {
    logic valid;
    out_t item;
  } res_t;

  // Status codes.
  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_NO_START  = 3'd1;
  localparam logic [2:0] ST_TRUNCATED = 3'd2;
  localparam logic [2:0] ST_STOP      = 3'd3;
  localparam logic [2:0] ST_BAD_LEN   = 3'd4;
  localparam logic [2:0] ST_ZERO      = 3'd5;

endpackage
`default_nettype wire

[sv/jfsp_parser.sv]
`default_nettype none
module jfsp_parser
  import jfsp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire in_t  in_item,
  output res_t      res
);

  // Parse phases.
  localparam logic [3:0] PH_START0   = 4'd0;
  localparam logic [3:0] PH_START1   = 4'd1;
  localparam logic [3:0] PH_FILL     = 4'd2;
  localparam logic [3:0] PH_LEN_HI   = 4'd3;
  localparam logic [3:0] PH_LEN_LO   = 4'd4;
  localparam logic [3:0] PH_SKIP     = 4'd5;
  localparam logic [3:0] PH_SEEK     = 4'd6;
  localparam logic [3:0] PH_AFTER_FF = 4'd7;
  localparam logic [3:0] PH_HEADER   = 4'd8;

  // Marker bytes.
  localparam logic [7:0] MK_FILL  = 8'hFF;
  localparam logic [7:0] MK_SOI   = 8'hD8;
  localparam logic [7:0] MK_EOI   = 8'hD9;
  localparam logic [7:0] MK_SOS   = 8'hDA;
  localparam logic [7:0] MK_STUFF = 8'h00;
  localparam logic [7:0] MK_TEM   = 8'h01;
  localparam logic [7:0] MK_RST0  = 8'hD0;
  localparam logic [7:0] MK_RST7  = 8'hD7;
  localparam logic [7:0] MK_SOF0  = 8'hC0;
  localparam logic [7:0] MK_SOF15 = 8'hCF;
  localparam logic [7:0] MK_DHT   = 8'hC4;
  localparam logic [7:0] MK_JPG   = 8'hC8;
  localparam logic [7:0] MK_DAC   = 8'hCC;

  localparam logic [2:0] HDR_FIRST = 3'd2;
  localparam logic [2:0] HDR_H_HI  = 3'd3;
  localparam logic [2:0] HDR_H_LO  = 3'd4;
  localparam logic [2:0] HDR_W_HI  = 3'd5;
  localparam logic [2:0] HDR_W_LO  = 3'd6;
  localparam logic [2:0] HDR_DONE  = 3'd7;

  typedef struct packed {
    logic [3:0]  phase;
    logic [15:0] seg_left;
    logic [7:0]  len_hi;
    logic [2:0]  hdr_idx;
    logic [15:0] height;
    logic [15:0] width;
    logic        in_frame;
    logic        result_given;
  } pstate_t;

  pstate_t st_r, st_nxt;
  pstate_t cur, nxt;
  logic        done;
  logic [2:0]  code;
  logic [7:0]  b;
  logic [15:0] len;
  logic        is_rst;

  function automatic logic is_frame_marker(input logic [7:0] m);
    return (m >= MK_SOF0) && (m <= MK_SOF15) && (m != MK_DHT) && (m != MK_JPG) &&
           (m != MK_DAC);
  endfunction

  assign b      = in_item.data_byte;
  assign len    = {cur.len_hi, b};
  assign is_rst = (b >= MK_RST0) && (b <= MK_RST7);

  // Next state and result for the byte on the input.
  always_comb begin
    cur = st_r;
    if (in_item.first_byte) begin
      cur = '0;
      cur.phase = PH_START0;
    end
    nxt  = cur;
    done = 1'b0;
    code = ST_FOUND;
    if (!cur.result_given) begin
      unique case (cur.phase)
        PH_START0: begin
          if (b != MK_FILL) begin
            done = 1'b1;
            code = ST_NO_START;
          end else begin
            nxt.phase = PH_START1;
          end
        end
        PH_START1: begin
          if (b != MK_SOI) begin
            done = 1'b1;
            code = ST_NO_START;
          end else begin
            nxt.phase = PH_FILL;
          end
        end
        PH_FILL: begin
          if (b == MK_FILL) begin
            nxt.phase = PH_FILL;
          end else if (b == MK_EOI || b == MK_STUFF) begin
            done = 1'b1;
            code = ST_STOP;
          end else if (b == MK_SOI || b == MK_TEM || is_rst) begin
            nxt.phase = PH_SEEK;
          end else begin
            nxt.in_frame = 1'b0;
            nxt.phase    = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          nxt.len_hi = b;
          nxt.phase  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (cur.in_frame) begin
            if (len < 16'd5) begin
              done = 1'b1;
              code = ST_BAD_LEN;
            end else begin
              nxt.seg_left = len - 16'd2;
              nxt.hdr_idx  = HDR_FIRST;
              nxt.phase    = PH_HEADER;
            end
          end else if (len < 16'd2) begin
            done = 1'b1;
            code = ST_BAD_LEN;
          end else begin
            nxt.seg_left = len - 16'd2;
            nxt.phase    = (len == 16'd2) ? PH_SEEK : PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (cur.seg_left != 16'd0) begin
            nxt.seg_left = cur.seg_left - 16'd1;
          end
          if (nxt.seg_left == 16'd0) begin
            nxt.phase = PH_SEEK;
          end
        end
        PH_SEEK: begin
          if (b == MK_FILL) begin
            nxt.phase = PH_AFTER_FF;
          end
        end
        PH_AFTER_FF: begin
          if (b == MK_FILL) begin
            nxt.phase = PH_AFTER_FF;
          end else if (b == MK_STUFF || is_rst) begin
            nxt.phase = PH_SEEK;
          end else if (b == MK_EOI || b == MK_SOS) begin
            done = 1'b1;
            code = ST_STOP;
          end else begin
            nxt.in_frame = is_frame_marker(b);
            nxt.phase    = PH_LEN_HI;
          end
        end
        PH_HEADER: begin
          if (cur.hdr_idx < HDR_DONE) begin
            if (cur.hdr_idx == HDR_H_HI || cur.hdr_idx == HDR_H_LO) begin
              nxt.height = {cur.height[7:0], b};
            end else if (cur.hdr_idx == HDR_W_HI || cur.hdr_idx == HDR_W_LO) begin
              nxt.width = {cur.width[7:0], b};
            end
            nxt.hdr_idx = cur.hdr_idx + 3'd1;
          end
          if (cur.seg_left != 16'd0) begin
            nxt.seg_left = cur.seg_left - 16'd1;
          end
          if (nxt.hdr_idx == HDR_DONE && nxt.seg_left == 16'd0) begin
            done = 1'b1;
            code = (nxt.height == 16'd0 || nxt.width == 16'd0) ? ST_ZERO : ST_FOUND;
          end
        end
        default: begin
          nxt.phase = PH_START0;
        end
      endcase
      // A buffer that ends before any result is truncated.
      if (!done && in_item.last_byte) begin
        done = 1'b1;
        code = ST_TRUNCATED;
      end
    end
    if (done) begin
      nxt.result_given = 1'b1;
    end
  end

  assign st_nxt = in_fire ? nxt : st_r;

  // Result for the output stage; size fields are zero unless found.
  always_comb begin
    res.valid             = in_fire && done;
    res.item.status       = code;
    res.item.frame_width  = (code == ST_FOUND) ? nxt.width : 16'd0;
    res.item.frame_height = (code == ST_FOUND) ? nxt.height : 16'd0;
  end

  // Parser state register; the all-zero state expects the first start byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Once a result is given, later bytes of the buffer give none.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.result_given && !in_item.first_byte) |-> !res.valid)
    else $error("second result within one buffer");

  // A result marks the buffer as answered.
  a_mark_given: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> st_r.result_given)
    else $error("result not recorded");

  // The header byte index stays within the frame header.
  a_hdr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_HEADER) |-> (st_r.hdr_idx >= HDR_FIRST))
    else $error("header index out of range");

endmodule
`default_nettype wire

[sv/jfsp_out_stage.sv]
`default_nettype none
module jfsp_out_stage
  import jfsp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire res_t res,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_item
);

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  out_t out_r, out_nxt;
  out_t skid_r, skid_nxt;
  logic pop;

  assign pop       = out_valid_r && out_ready;
  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Output register with a skid entry behind it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (pop || !out_valid_r) begin
      out_nxt       = res.item;
      out_valid_nxt = res.valid;
    end else if (res.valid) begin
      skid_nxt       = res.item;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  // The skid entry is only used behind a full output register.
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry without output entry");

  // No result arrives while both entries are full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !res.valid)
    else $error("result dropped on full buffer");

  // A skid entry moves forward as soon as the output is taken.
  a_skid_move: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_ready) |=> (out_valid_r && !skid_valid_r))
    else $error("skid entry not forwarded");

endmodule
`default_nettype wire

[sv/jpeg_frame_size_probe.sv]
// JPEG frame size probe.
// The input channel (in_valid, in_ready, in_item) takes the file one byte per
// item, with first_byte marking the start of a buffer and last_byte its end.
// The result channel (out_valid, out_ready, out_item) gives one item per
// buffer: a status code and, when the status is found, the frame width and
// height from the first frame header.
// Throughput is one byte per cycle while in_ready is high. Each byte updates
// the parser state in the cycle it is accepted; a result it causes is
// registered in the output register (or the skid entry) for the result channel.
// The output register has a skid entry behind it, so bytes keep flowing while
// a result waits. If the receiver stalls with both entries full, in_ready
// drops until the output is taken.
// After a result the rest of the buffer is consumed without results until the
// next first_byte mark.
// Reset (rst_n low, synchronous) empties the result buffer and returns the
// parser to the state of a fresh buffer expecting FF D8.
`default_nettype none
module jpeg_frame_size_probe
  import jfsp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_item,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_item
);

  logic in_fire;
  res_t res;

  assign in_fire = in_valid && in_ready;

  jfsp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_item (in_item),
    .res     (res)
  );

  jfsp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
